// File: design/size_class_bitmap_allocator_defines.svh
// Assertion macros for the size-class allocator checks.
`ifndef SIZE_CLASS_BITMAP_ALLOCATOR_DEFINES_SVH
`define SIZE_CLASS_BITMAP_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SCBA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("scba check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SCBA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("scba check failed");

`endif

// File: design/scba_pkg.sv
`default_nettype none

package scba_pkg;

	localparam int unsigned ADDR_W    = 32;
	localparam int unsigned REQ_W     = 16;
	localparam int unsigned BYTES_W   = 11;
	localparam int unsigned MODE_W    = 2;
	localparam int unsigned CFG_IDX_W = 2;

	// request modes
	localparam logic [MODE_W-1:0] MODE_ALLOC = 2'd0;
	localparam logic [MODE_W-1:0] MODE_FREE  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_QUERY = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_SMALL_BASE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MEDIUM_BASE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LARGE_BASE  = 2'd2;

	localparam logic [ADDR_W-1:0] SMALL_BASE_RST  = 32'd0;
	localparam logic [ADDR_W-1:0] MEDIUM_BASE_RST = 32'd8192;
	localparam logic [ADDR_W-1:0] LARGE_BASE_RST  = 32'd16384;

	// class geometry
	localparam int unsigned       SMALL_COUNT  = 128;
	localparam logic [ADDR_W-1:0] SMALL_BLOCK  = 32'd64;
	localparam int unsigned       MEDIUM_COUNT = 16;
	localparam logic [ADDR_W-1:0] MEDIUM_BLOCK = 32'd512;
	localparam int unsigned       LARGE_COUNT  = 8;
	localparam logic [ADDR_W-1:0] LARGE_BLOCK  = 32'd1024;

	localparam int unsigned SMALL_IDX_W  = (SMALL_COUNT > 1) ? $clog2(SMALL_COUNT) : 1;
	localparam int unsigned MEDIUM_IDX_W = (MEDIUM_COUNT > 1) ? $clog2(MEDIUM_COUNT) : 1;
	localparam int unsigned LARGE_IDX_W  = (LARGE_COUNT > 1) ? $clog2(LARGE_COUNT) : 1;

	// region extents, one bit wider than an address so they never wrap
	localparam logic [ADDR_W:0] SMALL_SPAN  = (ADDR_W+1)'(SMALL_COUNT * SMALL_BLOCK);
	localparam logic [ADDR_W:0] MEDIUM_SPAN = (ADDR_W+1)'(MEDIUM_COUNT * MEDIUM_BLOCK);
	localparam logic [ADDR_W:0] LARGE_SPAN  = (ADDR_W+1)'(LARGE_COUNT * LARGE_BLOCK);

	localparam logic [BYTES_W-1:0] SMALL_BYTES  = SMALL_BLOCK[BYTES_W-1:0];
	localparam logic [BYTES_W-1:0] MEDIUM_BYTES = MEDIUM_BLOCK[BYTES_W-1:0];
	localparam logic [BYTES_W-1:0] LARGE_BYTES  = LARGE_BLOCK[BYTES_W-1:0];

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [REQ_W-1:0]  request_bytes;
		logic [ADDR_W-1:0] block_address;
	} req_t;

	typedef struct packed {
		logic [ADDR_W-1:0]  granted_address;
		logic               success;
		logic [BYTES_W-1:0] block_bytes;
	} rsp_t;

	typedef struct packed {
		logic [ADDR_W-1:0] small_base;
		logic [ADDR_W-1:0] medium_base;
		logic [ADDR_W-1:0] large_base;
	} base_cfg_t;

	function automatic logic in_region(logic [ADDR_W-1:0] base, logic [ADDR_W:0] span,
			logic [ADDR_W-1:0] a);
		logic [ADDR_W:0] a_x;
		logic [ADDR_W:0] base_x;
		a_x    = {1'b0, a};
		base_x = {1'b0, base};
		return (a_x >= base_x) && (a_x < base_x + span);
	endfunction

endpackage

`default_nettype wire

// File: design/scba_req_if.sv
`default_nettype none

interface scba_req_if;
	logic                          valid;
	logic                          ready;
	logic [scba_pkg::MODE_W-1:0]   mode;
	logic [scba_pkg::REQ_W-1:0]    request_bytes;
	logic [scba_pkg::ADDR_W-1:0]   block_address;

	modport source (output valid, output mode, output request_bytes, output block_address,
		input ready);
	modport sink (input valid, input mode, input request_bytes, input block_address,
		output ready);
endinterface

`default_nettype wire

// File: design/scba_rsp_if.sv
`default_nettype none

interface scba_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [scba_pkg::ADDR_W-1:0]   granted_address;
	logic                          success;
	logic [scba_pkg::BYTES_W-1:0]  block_bytes;

	modport source (output valid, output granted_address, output success, output block_bytes,
		input ready);
	modport sink (input valid, input granted_address, input success, input block_bytes,
		output ready);
endinterface

`default_nettype wire

// File: design/scba_maps.sv
`default_nettype none

module scba_maps (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                fire,
	input  scba_pkg::req_t      req,
	input  scba_pkg::base_cfg_t base,
	output scba_pkg::rsp_t      rsp
);
	import scba_pkg::*;

	logic [SMALL_COUNT-1:0]  small_map_q;
	logic [MEDIUM_COUNT-1:0] medium_map_q;
	logic [LARGE_COUNT-1:0]  large_map_q;

	logic [ADDR_W-1:0] want;
	logic s_in, m_in, l_in;
	logic [ADDR_W-1:0] s_off, m_off, l_off;
	logic [ADDR_W-1:0] s_quo, m_quo, l_quo;
	logic [SMALL_IDX_W-1:0]  s_idx, s_ffs;
	logic [MEDIUM_IDX_W-1:0] m_idx, m_ffs;
	logic [LARGE_IDX_W-1:0]  l_idx, l_ffs;
	logic s_take, m_take, l_take;
	logic [ADDR_W-1:0] s_addr, m_addr, l_addr;

	assign want = ADDR_W'(req.request_bytes);

	// region hits and block index of the address
	assign s_in  = in_region(base.small_base, SMALL_SPAN, req.block_address);
	assign m_in  = in_region(base.medium_base, MEDIUM_SPAN, req.block_address);
	assign l_in  = in_region(base.large_base, LARGE_SPAN, req.block_address);
	assign s_off = req.block_address - base.small_base;
	assign m_off = req.block_address - base.medium_base;
	assign l_off = req.block_address - base.large_base;
	assign s_quo = s_off / SMALL_BLOCK;
	assign m_quo = m_off / MEDIUM_BLOCK;
	assign l_quo = l_off / LARGE_BLOCK;
	assign s_idx = s_quo[SMALL_IDX_W-1:0];
	assign m_idx = m_quo[MEDIUM_IDX_W-1:0];
	assign l_idx = l_quo[LARGE_IDX_W-1:0];

	// lowest clear bit of each map; scanning down leaves the lowest one
	always_comb begin
		s_ffs = '0;
		for (int i = SMALL_COUNT - 1; i >= 0; i--) begin
			if (!small_map_q[i]) s_ffs = SMALL_IDX_W'(i);
		end
	end

	always_comb begin
		m_ffs = '0;
		for (int i = MEDIUM_COUNT - 1; i >= 0; i--) begin
			if (!medium_map_q[i]) m_ffs = MEDIUM_IDX_W'(i);
		end
	end

	always_comb begin
		l_ffs = '0;
		for (int i = LARGE_COUNT - 1; i >= 0; i--) begin
			if (!large_map_q[i]) l_ffs = LARGE_IDX_W'(i);
		end
	end

	assign s_take = (want <= SMALL_BLOCK) && !(&small_map_q);
	assign m_take = !s_take && (want <= MEDIUM_BLOCK) && !(&medium_map_q);
	assign l_take = !s_take && !m_take && (want <= LARGE_BLOCK) && !(&large_map_q);

	assign s_addr = base.small_base + ADDR_W'(s_ffs) * SMALL_BLOCK;
	assign m_addr = base.medium_base + ADDR_W'(m_ffs) * MEDIUM_BLOCK;
	assign l_addr = base.large_base + ADDR_W'(l_ffs) * LARGE_BLOCK;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			small_map_q  <= '0;
			medium_map_q <= '0;
			large_map_q  <= '0;
		end else if (fire) begin
			case (req.mode)
				MODE_ALLOC: begin
					if (s_take) small_map_q[s_ffs] <= 1'b1;
					if (m_take) medium_map_q[m_ffs] <= 1'b1;
					if (l_take) large_map_q[l_ffs] <= 1'b1;
				end
				MODE_FREE: begin
					// overlapping regions all drop their block
					if (s_in) small_map_q[s_idx] <= 1'b0;
					if (m_in) medium_map_q[m_idx] <= 1'b0;
					if (l_in) large_map_q[l_idx] <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		rsp = '0;
		case (req.mode)
			MODE_ALLOC: begin
				if (s_take) begin
					rsp.granted_address = s_addr;
					rsp.success         = 1'b1;
				end else if (m_take) begin
					rsp.granted_address = m_addr;
					rsp.success         = 1'b1;
				end else if (l_take) begin
					rsp.granted_address = l_addr;
					rsp.success         = 1'b1;
				end
			end
			MODE_FREE: rsp.success = s_in || m_in || l_in;
			MODE_QUERY: begin
				if (s_in)      rsp.block_bytes = SMALL_BYTES;
				else if (m_in) rsp.block_bytes = MEDIUM_BYTES;
				else if (l_in) rsp.block_bytes = LARGE_BYTES;
			end
			default: ;
		endcase
	end

endmodule

`default_nettype wire

// File: design/size_class_bitmap_allocator.sv
// Channel   Dir  Payload                                      Handshake
// req       in   mode, request_bytes, block_address           valid/ready
// rsp       out  granted_address, success, block_bytes        valid/ready
// cfg       in   cfg_index, cfg_data (region bases)           cfg_we, no stall
//
// One request per cycle sustained while rsp.ready stays high; a response
// reaches rsp after its request passes the input register, then the
// response register.
// The bitmap read-modify-write of the three class maps happens as a request
// leaves the input register, so the request that follows sees the maps already updated.
// Reset clears all three used maps and loads the default region bases.
// A stalled response holds its register and the input register; req.ready
// drops only when both are full and rsp.ready is low.
`default_nettype none

module size_class_bitmap_allocator (
	input  logic                              clk,
	input  logic                              arst_n,
	scba_req_if.sink                          req,
	scba_rsp_if.source                        rsp,
	input  logic                              cfg_we,
	input  logic [scba_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [scba_pkg::ADDR_W-1:0]       cfg_data
);
	import scba_pkg::*;

	base_cfg_t base_q;

	logic  valid_s1;
	req_t  req_s1;
	logic  valid_s2;
	rsp_t  rsp_s2;

	logic  accept;
	logic  advance;
	rsp_t  map_rsp;

	// Region base registers; writes to an unused index drop silently.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q.small_base  <= SMALL_BASE_RST;
			base_q.medium_base <= MEDIUM_BASE_RST;
			base_q.large_base  <= LARGE_BASE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SMALL_BASE:  base_q.small_base  <= cfg_data;
				CFG_MEDIUM_BASE: base_q.medium_base <= cfg_data;
				CFG_LARGE_BASE:  base_q.large_base  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Advance the held request whenever the response register is free or
	// being emptied this cycle.
	assign advance   = valid_s1 && (!valid_s2 || rsp.ready);
	assign req.ready = !valid_s1 || advance;
	assign accept    = req.valid && req.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// Capture the request payload; no reset needed.
	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1.mode          <= req.mode;
			req_s1.request_bytes <= req.request_bytes;
			req_s1.block_address <= req.block_address;
		end
	end

	// Bitmaps, find-first-free, region decode and response formation.
	scba_maps u_maps (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (advance),
		.req    (req_s1),
		.base   (base_q),
		.rsp    (map_rsp)
	);

	// Response register; hold while the sink stalls.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (rsp.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) rsp_s2 <= map_rsp;
	end

	assign rsp.valid           = valid_s2;
	assign rsp.granted_address = rsp_s2.granted_address;
	assign rsp.success         = rsp_s2.success;
	assign rsp.block_bytes     = rsp_s2.block_bytes;

endmodule

`default_nettype wire

// File: design/scba_checker.sv
`default_nettype none
`include "size_class_bitmap_allocator_defines.svh"

module scba_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             req_valid,
	input  logic                             req_ready,
	input  logic                             rsp_valid,
	input  logic                             rsp_ready,
	input  logic [scba_pkg::ADDR_W-1:0]      granted_address,
	input  logic                             success,
	input  logic [scba_pkg::BYTES_W-1:0]     block_bytes
);

	// hold a stalled response
	`SCBA_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(granted_address) && $stable(success) && $stable(block_bytes))

	// a nonzero address is only ever a grant
	`SCBA_ASSERT_IMPL(a_addr_is_grant, clk, arst_n, rsp_valid && (granted_address != '0), success)

	// success never comes with a block size
	`SCBA_ASSERT_IMPL(a_success_no_bytes, clk, arst_n, rsp_valid && success, block_bytes == '0)

	// a fresh response follows an accepted request through the input and response registers
	`SCBA_ASSERT_IMPL(a_rsp_latency, clk, arst_n, $rose(rsp_valid), $past(req_valid && req_ready, 2))

endmodule

bind size_class_bitmap_allocator scba_checker u_scba_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.req_valid       (req.valid),
	.req_ready       (req.ready),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.granted_address (rsp.granted_address),
	.success         (rsp.success),
	.block_bytes     (rsp.block_bytes)
);

`default_nettype wire
